### design/evtt_pkg.sv
// Package for the eased value tween table: payload structs and constants.
// No dependencies.
package evtt_pkg;

  typedef struct packed {
    logic        op;
    logic [15:0] context_tag;
    logic [31:0] key_hash;
    logic signed [31:0] target_value;
    logic [15:0] ramp_ms;
    logic [63:0] now_ns;
  } evtt_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               context_active;
  } evtt_out_t;

  localparam logic OP_ANIMATE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;
  localparam int unsigned TOL = 66;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

endpackage

### design/eased_value_tween_table.sv
// Eased value tween table top level: slot memory, sequencer, divider, easing.
// Depends on evtt_pkg.
//
// Usage: one transaction on in_ (valid/stall) yields exactly one transaction on
// out_. An animate transaction finds or allocates the slot of (context, key),
// ramps its value along a cubic ease-out and returns it; a clear transaction
// frees every slot of a context and returns zero. Both report whether the
// context still has a slot in motion.
// Flow: a scan over all SLOTS entries of the slot memory (one entry read a
// cycle), then for a ramp a 16-step restoring divide of the elapsed time by
// the duration and the cube and product multiplies, then a second scan for
// the activity flag. One transaction is worked at a time.
// in_stall is high while a transaction is being worked. Reset clears the used
// bits (one flip-flop per slot) and the sequencer; the slot memory itself needs
// no clearing. While out_stall is high the result is held in the output
// register; the next transaction may be taken and worked, but its result waits
// with in_stall high until the held one is accepted.
module eased_value_tween_table
  import evtt_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  evtt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output evtt_out_t out_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [15:0] ctx;
    logic [31:0] key;
    logic signed [31:0] cur;
    logic signed [31:0] start;
    logic signed [31:0] tgt;
    logic [15:0] dur;
    logic [63:0] t0;
  } slot_t;

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SEL = 4'd2, S_RD = 4'd3,
    S_UPD = 4'd4, S_DIV = 4'd5, S_CUBE1 = 4'd6, S_CUBE2 = 4'd7, S_MUL = 4'd8,
    S_FIN = 4'd9, S_ACT = 4'd10, S_OUT = 4'd11, S_STEP = 4'd12;

  slot_t mem [SLOTS];
  slot_t rd_r;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [3:0] st_r, st_nxt;
  evtt_in_t req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] raddr;
  logic [AW-1:0] rsel_r, rsel_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] hit_r, hit_nxt, free_r, free_nxt;
  logic          hitv_r, hitv_nxt, freev_r, freev_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  slot_t s_r, s_nxt;
  logic          we;
  logic [AW-1:0] waddr;
  slot_t wdata;
  logic          act_r, act_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic          ovld_r, ovld_nxt;
  evtt_out_t     out_r, out_nxt;
  // divider
  logic [63:0] el_r, el_nxt;
  logic [35:0] dns_r, dns_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic [4:0]  dc_r, dc_nxt;
  logic        pone_r, pone_nxt;
  logic [33:0] sq_r, sq_nxt;
  logic [16:0] eased_r, eased_nxt;
  logic signed [50:0] prod_r, prod_nxt;

  logic [16:0] r_w;
  logic [50:0] cube_w;
  logic signed [32:0] diff_w;
  logic [50:0] negp_w;
  logic signed [33:0] step_w, curw, dt_w;
  logic [64:0] trial_w;

  assign raddr = cnt_r[AW-1:0];
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ovld_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; cnt_nxt = cnt_r; rsel_nxt = rsel_r; rv_nxt = 1'b0;
    hit_nxt = hit_r; hitv_nxt = hitv_r; free_nxt = free_r; freev_nxt = freev_r;
    idx_nxt = idx_r; s_nxt = s_r; used_nxt = used_r; act_nxt = act_r; val_nxt = val_r;
    ovld_nxt = ovld_r; el_nxt = el_r; dns_nxt = dns_r; rem_nxt = rem_r; q_nxt = q_r;
    dc_nxt = dc_r; pone_nxt = pone_r; sq_nxt = sq_r; eased_nxt = eased_r;
    prod_nxt = prod_r; we = 1'b0; waddr = idx_r; wdata = s_r; out_nxt = out_r;
    r_w = ONE_Q16 - q_r;
    cube_w = 51'(sq_r) * 51'(r_w);
    diff_w = 33'(s_r.tgt) - 33'(s_r.start);
    negp_w = 51'(-prod_r);
    if (prod_r >= 0) step_w = 34'(prod_r >>> 16);
    else step_w = -34'((negp_w + 51'd65535) >> 16);
    curw = 34'(s_r.start) + step_w;
    dt_w = 34'(s_r.cur) - 34'(s_r.tgt);
    trial_w = {rem_r[63:0], el_r[63]};
    if (out_valid && !out_stall) ovld_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        req_nxt = in_data; cnt_nxt = '0; hitv_nxt = 1'b0; freev_nxt = 1'b0;
        act_nxt = 1'b0; st_nxt = S_SCAN;
      end
      S_SCAN: begin
        // reads are issued at cnt and checked in the next cycle at rsel
        if (rv_r && used_r[rsel_r] && rd_r.ctx == req_r.context_tag) begin
          if (req_r.op == OP_CLEAR) used_nxt[rsel_r] = 1'b0;
          else if (!hitv_r && rd_r.key == req_r.key_hash) begin
            hitv_nxt = 1'b1; hit_nxt = rsel_r;
          end
        end
        if (rv_r && !used_r[rsel_r] && !freev_r) begin
          freev_nxt = 1'b1; free_nxt = rsel_r;
        end
        if (cnt_r < CW'(SLOTS)) begin
          rsel_nxt = raddr; rv_nxt = 1'b1; cnt_nxt = cnt_r + 1'b1;
        end else if (!rv_r) begin
          if (req_r.op == OP_CLEAR) begin
            val_nxt = '0; cnt_nxt = '0; st_nxt = S_ACT;
          end else st_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (hitv_r) idx_nxt = hit_r;
        else if (freev_r) idx_nxt = free_r;
        else idx_nxt = '0;
        cnt_nxt = CW'(hitv_r ? hit_r : (freev_r ? free_r : '0));
        st_nxt = S_RD;
      end
      S_RD: st_nxt = S_UPD;
      S_UPD: begin
        s_nxt = rd_r;
        if (!hitv_r) begin
          s_nxt.ctx = req_r.context_tag; s_nxt.key = req_r.key_hash;
          s_nxt.cur = req_r.target_value; s_nxt.start = req_r.target_value;
          s_nxt.tgt = req_r.target_value; s_nxt.dur = '0; s_nxt.t0 = req_r.now_ns;
          used_nxt[idx_r] = 1'b1;
        end else if (rd_r.tgt != req_r.target_value) begin
          s_nxt.start = rd_r.cur; s_nxt.tgt = req_r.target_value;
          s_nxt.dur = req_r.ramp_ms; s_nxt.t0 = req_r.now_ns;
        end
        if (s_nxt.cur == req_r.target_value) begin
          val_nxt = s_nxt.cur; st_nxt = S_FIN;
        end else begin
          el_nxt = req_r.now_ns - s_nxt.t0;
          dns_nxt = 36'(s_nxt.dur) * 36'(NS_PER_MS);
          rem_nxt = '0; q_nxt = '0; dc_nxt = '0; st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dc_r == 5'd0) begin
          pone_nxt = (dns_r == '0) || (el_r >= 64'(dns_r));
          // elapsed < dns: the leading quotient bits are zero and the
          // remainder is elapsed itself; only the 16 fraction bits remain
          rem_nxt = 65'(el_r); el_nxt = '0;
          dc_nxt = 5'd1;
          if (pone_nxt) begin q_nxt = ONE_Q16; st_nxt = S_CUBE1; end
        end else begin
          if (trial_w >= 65'(dns_r)) begin
            rem_nxt = trial_w - 65'(dns_r); q_nxt = {q_r[15:0], 1'b1};
          end else begin
            rem_nxt = trial_w; q_nxt = {q_r[15:0], 1'b0};
          end
          el_nxt = el_r << 1;
          dc_nxt = dc_r + 1'b1;
          if (dc_r == 5'd16) st_nxt = S_CUBE1;
        end
      end
      S_CUBE1: begin sq_nxt = 34'(r_w) * 34'(r_w); st_nxt = S_CUBE2; end
      S_CUBE2: begin
        eased_nxt = ONE_Q16 - 17'(cube_w >> 32); st_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = 51'(diff_w) * $signed({1'b0, eased_r});
        st_nxt = S_STEP;
      end
      S_STEP: begin
        s_nxt.cur = 32'(curw);
        if (pone_r || ((curw - 34'(s_r.tgt)) < 34'sd66 &&
                       (curw - 34'(s_r.tgt)) > -34'sd66))
          s_nxt.cur = s_r.tgt;
        val_nxt = s_nxt.cur; st_nxt = S_FIN;
      end
      S_FIN: begin
        we = 1'b1; cnt_nxt = '0; st_nxt = S_ACT;
      end
      S_ACT: begin
        if (rv_r && used_r[rsel_r] && rd_r.ctx == req_r.context_tag) begin
          dt_w = 34'(rd_r.cur) - 34'(rd_r.tgt);
          if (dt_w >= 34'sd66 || dt_w <= -34'sd66) act_nxt = 1'b1;
        end
        if (cnt_r < CW'(SLOTS)) begin
          rsel_nxt = raddr; rv_nxt = 1'b1; cnt_nxt = cnt_r + 1'b1;
        end else if (!rv_r) st_nxt = S_OUT;
      end
      S_OUT: if (!ovld_r || !out_stall) begin
        ovld_nxt = 1'b1; st_nxt = S_IDLE;
        out_nxt.value = val_r; out_nxt.context_active = act_r;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; used_r <= '0; ovld_r <= 1'b0; rv_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt; used_r <= used_nxt; ovld_r <= ovld_nxt; rv_r <= rv_nxt;
      cnt_r <= cnt_nxt;
    end
    req_r <= req_nxt; rsel_r <= rsel_nxt; hit_r <= hit_nxt; hitv_r <= hitv_nxt;
    free_r <= free_nxt; freev_r <= freev_nxt; idx_r <= idx_nxt; s_r <= s_nxt;
    act_r <= act_nxt; val_r <= val_nxt; el_r <= el_nxt; dns_r <= dns_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt; dc_r <= dc_nxt; pone_r <= pone_nxt;
    sq_r <= sq_nxt; eased_r <= eased_nxt; prod_r <= prod_nxt; out_r <= out_nxt;
  end

endmodule
